@@ rtl/spq_pkg.sv @@
// Package for the sorted-insert priority queue.
// Request/response payload types, status codes and defaults; no dependencies.
package spq_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int DATA_W        = 32;
   localparam int FILL_W        = 8;

   typedef enum logic {
      MODE_ENQ = 1'b0,
      MODE_DEQ = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   localparam logic signed [DATA_W-1:0] EMPTY_ITEM = -32'sd1;

   typedef struct packed {
      mode_type                   mode;
      logic signed [DATA_W-1:0]   item_in;
      logic signed [DATA_W-1:0]   prio_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   item_out;
      status_type                 status;
      logic [FILL_W-1:0]          fill_count;
   } rsp_type;

   // contents of one queue cell
   typedef struct packed {
      logic                       valid;
      logic signed [DATA_W-1:0]   item;
      logic signed [DATA_W-1:0]   prio;
   } entry_type;

   // broadcast control to every cell
   typedef struct packed {
      logic                       enq;
      logic                       deq;
      logic signed [DATA_W-1:0]   item;
      logic signed [DATA_W-1:0]   prio;
   } cell_ctl_type;

endpackage

@@ rtl/spq_cell.sv @@
// One cell of the queue's systolic row: holds one entry and trades with neighbors.
// Depends on spq_pkg (entry_type, cell_ctl_type).
module spq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::entry_type   lower,
   input  logic                 lower_keep,
   input  spq_pkg::entry_type   upper,
   output spq_pkg::entry_type   entry,
   output logic                 keep
);

   logic                       valid_ff, valid_in;
   logic signed [31:0]         item_ff, item_in;
   logic signed [31:0]         prio_ff, prio_in;

   // cell 0 is the tail (lowest priority, newest among equals)
   // an entry stays put on insert when its priority is below the new one
   assign keep = valid_ff && (prio_ff < ctl.prio);

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      prio_in  = prio_ff;
      if (ctl.deq) begin
         valid_in = upper.valid;
         item_in  = upper.item;
         prio_in  = upper.prio;
      end else if (ctl.enq && !keep) begin
         if (lower_keep) begin
            valid_in = 1'b1;
            item_in  = ctl.item;
            prio_in  = ctl.prio;
         end else begin
            valid_in = lower.valid;
            item_in  = lower.item;
            prio_in  = lower.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
      prio_ff <= prio_in;
   end

   assign entry.valid = valid_ff;
   assign entry.item  = item_ff;
   assign entry.prio  = prio_ff;

endmodule

@@ rtl/sorted_insert_priority_queue.sv @@
// Top level of the sorted-insert priority queue: a row of DEPTH spq_cell stages.
// Depends on spq_pkg and spq_cell.
//
//   channel   ports                       direction  handshake
//   request   start, busy, req_data       in         start && !busy
//   response  rsp_strobe, rsp_data        out        rsp_strobe, one cycle
//
// One request per cycle while busy is low; its response appears on the following cycle.
// The rate is set by the cell row: every cell compares and shifts in parallel.
// busy is high while reset is held and for the cycle after it; valid bits clear at once.
// The receiver cannot stall: each response is shown for exactly one cycle.
module sorted_insert_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spq_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output spq_pkg::rsp_type  rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   spq_pkg::entry_type        cells [DEPTH];
   logic [DEPTH-1:0]          keeps;
   logic [DEPTH-1:0]          valids;
   spq_pkg::cell_ctl_type     ctl;

   logic                      busy_ff;
   logic                      rsp_strobe_ff;
   spq_pkg::rsp_type          rsp_ff, rsp_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      accept, full, empty;

   assign accept = start && !busy_ff;
   assign full   = cells[DEPTH-1].valid;
   assign empty  = !cells[0].valid;

   assign ctl.enq  = accept && (req_data.mode == spq_pkg::MODE_ENQ) && !full;
   assign ctl.deq  = accept && (req_data.mode == spq_pkg::MODE_DEQ) && !empty;
   assign ctl.item = req_data.item_in;
   assign ctl.prio = req_data.prio_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type lower_e, upper_e;
      logic               lower_k;
      if (i == 0) begin : g_tail
         assign lower_e = '0;
         assign lower_k = 1'b1;
      end else begin : g_mid
         assign lower_e = cells[i-1];
         assign lower_k = keeps[i-1];
      end
      if (i == DEPTH - 1) begin : g_head
         assign upper_e = '0;
      end else begin : g_below
         assign upper_e = cells[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .lower      (lower_e),
         .lower_keep (lower_k),
         .upper      (upper_e),
         .entry      (cells[i]),
         .keep       (keeps[i])
      );
      assign valids[i] = cells[i].valid;
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (req_data.mode == spq_pkg::MODE_ENQ) begin
         rsp_in.item_out = '0;
         if (full) begin
            rsp_in.status = spq_pkg::ST_FULL;
         end else begin
            count_in      = count_ff + 1'b1;
            rsp_in.status = spq_pkg::ST_ENQUEUED;
         end
      end else begin
         if (empty) begin
            rsp_in.item_out = spq_pkg::EMPTY_ITEM;
            rsp_in.status   = spq_pkg::ST_EMPTY;
         end else begin
            count_in        = count_ff - 1'b1;
            rsp_in.item_out = cells[0].item;
            rsp_in.status   = spq_pkg::ST_DEQUEUED;
         end
      end
      rsp_in.fill_count = spq_pkg::FILL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // occupied cells form a contiguous run from the tail
   a_valid_thermo: assert property (@(posedge clock) disable iff (reset)
      (valids & (valids + 1'b1)) == '0)
      else $error("cell valid bits not contiguous");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valids) == int'(count_ff))
      else $error("entry count disagrees with cell valid bits");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("response without a request");

   a_full_refuse_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && full && req_data.mode == spq_pkg::MODE_ENQ) |=> $stable(count_ff))
      else $error("refused enqueue changed the count");

endmodule
